@@ rtl/core/slcd_pkg.sv @@
// Shared types and constants for the sync/length/checksum deframer.
package slcd_pkg;

    // Frame sync pattern
    localparam logic [7:0] SYNC1 = 8'hA5;
    localparam logic [7:0] SYNC2 = 8'h5A;

    // Default and field widths
    localparam int DEFAULT_MAX_PAYLOAD = 1024;
    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 10;
    localparam int LENGTH_W = 11;
    localparam int DECL_W   = 16;
    localparam int KIND_W   = 2;
    localparam int MDATA_W  = 32;

    // Parser phase
    typedef enum logic [2:0] {
        PH_HEAD1 = 3'd0,
        PH_HEAD2 = 3'd1,
        PH_LENL  = 3'd2,
        PH_LENH  = 3'd3,
        PH_DATA  = 3'd4,
        PH_SUM   = 3'd5
    } slcd_phase_t;

    // Result kind
    typedef enum logic [KIND_W-1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_GOOD    = 2'd1,
        KIND_BAD     = 2'd2
    } slcd_kind_t;

    // One result item from the parser
    typedef struct packed {
        logic                valid;
        slcd_kind_t          kind;
        logic [BYTE_W-1:0]   data;
        logic [INDEX_W-1:0]  index;
        logic [LENGTH_W-1:0] length;
    } slcd_result_t;

endpackage

@@ rtl/core/sync_length_checksum_deframer.sv @@
// Top level of the sync/length/checksum deframer.
//
// Takes one received byte per request and sustains one byte per clock cycle
// while the output is not back-pressured. A byte is captured in an input
// register and consumed by the parser once the output register can take its
// result, which is then registered there and raises m_tvalid. Frames are
// A5 5A, length low, length high, payload, checksum; a length above
// MAX_PAYLOAD drops the frame. Payload bytes come out with kind 0 and their
// index; the checksum byte comes out with kind 1 (sum matches) or 2
// (mismatch), index 0. A zero-length frame consumes one slack byte before
// the checksum. Backpressure on the output stalls the input register and
// then s_tready.
module sync_length_checksum_deframer
    import slcd_pkg::*;
#(
    parameter int MAX_PAYLOAD = DEFAULT_MAX_PAYLOAD
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [BYTE_W-1:0]  s_tdata,   // [7:0] rx_byte
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [MDATA_W-1:0] m_tdata,   // [7:0] out_byte, [17:8] out_index,
                                          // [28:18] frame_length, [31:29] zero
    output logic [KIND_W-1:0]  m_tuser    // [1:0] out_kind
);

    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              advance;
    slcd_result_t      result;

    // Consume the held byte when the output register can take its result
    assign advance  = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb
    begin
        priority if (s_tvalid && s_tready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_byte_reg <= s_tdata;
    end

    slcd_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .result  (result)
    );

    slcd_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance && result.valid),
        .result   (result),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // The input stage never refuses a request while it is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg)
        else $error("input stage stalled while empty");

    // An accepted byte is held in the input stage in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> in_valid_reg)
        else $error("accepted byte lost");

    // Frame-end results carry index zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != KIND_PAYLOAD) |-> m_tdata[17:8] == '0)
        else $error("frame-end result with nonzero index");

    // A result is only loaded when the parser consumes a byte
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> in_valid_reg)
        else $error("result produced without a held byte");

endmodule

@@ rtl/core/slcd_parser.sv @@
// Frame parser: phase, length, byte count and running sum.
module slcd_parser
    import slcd_pkg::*;
#(
    parameter int MAX_PAYLOAD = DEFAULT_MAX_PAYLOAD
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] rx_byte,
    output slcd_result_t      result
);

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

    slcd_phase_t         phase_reg, phase_next;
    logic [DECL_W-1:0]   length_reg, length_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [BYTE_W-1:0]   sum_reg, sum_next;
    logic [DECL_W-1:0]   count_ext;
    logic [DECL_W-1:0]   count_inc_ext;
    logic [DECL_W-1:0]   new_length;
    logic                oversize;

    assign count_ext     = DECL_W'(count_reg);
    assign count_inc_ext = DECL_W'(count_reg + 1'b1);
    assign new_length    = {rx_byte, length_reg[BYTE_W-1:0]};
    assign oversize      = {1'b0, new_length} > (DECL_W + 1)'(MAX_PAYLOAD);

    // Next state
    always_comb
    begin
        phase_next  = phase_reg;
        length_next = length_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        if (step)
        begin
            unique case (phase_reg)
                PH_HEAD1:
                begin
                    if (rx_byte == SYNC1)
                        phase_next = PH_HEAD2;
                end
                PH_HEAD2:
                begin
                    if (rx_byte == SYNC2)
                    begin
                        phase_next  = PH_LENL;
                        length_next = '0;
                    end
                    else
                    begin
                        phase_next = PH_HEAD1;
                    end
                end
                PH_LENL:
                begin
                    length_next = {length_reg[DECL_W-1:BYTE_W], rx_byte};
                    phase_next  = PH_LENH;
                end
                PH_LENH:
                begin
                    length_next = new_length;
                    if (oversize)
                    begin
                        phase_next = PH_HEAD1;
                    end
                    else
                    begin
                        count_next = '0;
                        sum_next   = '0;
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    if (count_ext < length_reg)
                        sum_next = sum_reg + rx_byte;
                    count_next = count_reg + 1'b1;
                    if (count_inc_ext >= length_reg)
                        phase_next = PH_SUM;
                end
                PH_SUM:
                begin
                    phase_next = PH_HEAD1;
                end
                default:
                begin
                    phase_next = PH_HEAD1;
                end
            endcase
        end
    end

    // Result for the byte being consumed
    always_comb
    begin
        result.valid  = 1'b0;
        result.kind   = KIND_PAYLOAD;
        result.data   = rx_byte;
        result.index  = INDEX_W'(count_reg);
        result.length = length_reg[LENGTH_W-1:0];
        unique case (phase_reg)
            PH_DATA:
            begin
                result.valid = step && (count_ext < length_reg);
            end
            PH_SUM:
            begin
                result.valid = step;
                result.kind  = (sum_reg == rx_byte) ? KIND_GOOD : KIND_BAD;
                result.index = '0;
            end
            default:
            begin
                result.valid = 1'b0;
            end
        endcase
    end

    // Hold parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEAD1;
            length_reg <= '0;
            count_reg  <= '0;
            sum_reg    <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            sum_reg    <= sum_next;
        end
    end

endmodule

@@ rtl/core/slcd_out_stage.sv @@
// Output register that holds one result request until the sink takes it.
module slcd_out_stage
    import slcd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  slcd_result_t       result,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [MDATA_W-1:0] m_tdata,
    output logic [KIND_W-1:0]  m_tuser
);

    logic                valid_reg, valid_next;
    slcd_kind_t          kind_reg;
    logic [BYTE_W-1:0]   data_reg;
    logic [INDEX_W-1:0]  index_reg;
    logic [LENGTH_W-1:0] length_reg;

    // Fill on load, drain when the sink takes the request
    always_comb
    begin
        priority if (load)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Capture payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg   <= result.kind;
            data_reg   <= result.data;
            index_reg  <= result.index;
            length_reg <= result.length;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = MDATA_W'({length_reg, index_reg, data_reg});

endmodule
